### sv/ffha_pkg.sv
// Shared types and constants of the first-fit heap allocator.
`default_nettype none
package ffha_pkg;

	localparam int OFF_W = 16;
	localparam int ALU_W = 18;
	localparam int HDR_W = 17;

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	localparam logic [1:0] ST_ALLOCATED = 2'd0;
	localparam logic [1:0] ST_FREED     = 2'd1;
	localparam logic [1:0] ST_NO_SPACE  = 2'd2;

	localparam logic [15:0] LIMIT_RESET = 16'd32768;

	typedef enum logic [1:0] {
		ALU_ADD = 2'b01,
		ALU_SUB = 2'b10
	} alu_op_t;

	typedef struct packed {
		alu_op_t            op;
		logic [ALU_W-1:0]   a;
		logic [ALU_W-1:0]   b;
	} alu_req_t;

	typedef struct packed {
		logic [ALU_W-1:0]   sum;
		logic               lt;
	} alu_res_t;

endpackage
`default_nettype wire

### sv/ffha_req_if.sv
// Request channel interface: operation, request size and address to free.
`default_nettype none
interface ffha_req_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [15:0] req_size;
	logic [14:0] free_addr;

	modport source (output valid, output func, output req_size, output free_addr, input ready);
	modport sink   (input valid, input func, input req_size, input free_addr, output ready);
endinterface
`default_nettype wire

### sv/ffha_rsp_if.sv
// Response channel interface: payload address and status.
`default_nettype none
interface ffha_rsp_if;
	logic        valid;
	logic        ready;
	logic [14:0] payload_addr;
	logic [1:0]  status;

	modport source (output valid, output payload_addr, output status, input ready);
	modport sink   (input valid, input payload_addr, input status, output ready);
endinterface
`default_nettype wire

### sv/ffha_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module ffha_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 4096,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

### sv/ffha_alu.sv
// Shared add/subtract unit with borrow flag.
`default_nettype none
module ffha_alu
	import ffha_pkg::*;
(
	input  wire alu_req_t req,
	output alu_res_t      res
);
	logic [ALU_W:0]   full;
	logic [ALU_W-1:0] b_eff;
	logic             sub;

	always_comb begin
		case (req.op)
			ALU_SUB: sub = 1'b1;
			ALU_ADD: sub = 1'b0;
			default: sub = 1'b0;
		endcase
		b_eff   = sub ? ~req.b : req.b;
		full    = {1'b0, req.a} + {1'b0, b_eff} + {{ALU_W{1'b0}}, sub};
		res.sum = full[ALU_W-1:0];
		res.lt  = sub & ~full[ALU_W];
	end
endmodule
`default_nettype wire

### sv/first_fit_heap_allocator.sv
// Top level: first-fit heap allocator over an implicit list of block headers.
// Allocate: walks the block list for the first free fit, else grows the heap top.
// Free: frees a block, merging a free next one; result sits in output until taken.
// One item at a time; the next item is taken the cycle after the result is loaded.
// Reset clears heap top to zero and the limit to 32768; header RAM is not cleared.
`default_nettype none
module first_fit_heap_allocator
	import ffha_pkg::*;
#(
	parameter int HEAP_GRANULES = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [15:0] cfg_wr_data,
	ffha_req_if.sink         req,
	ffha_rsp_if.source       rsp
);
	localparam int AW      = (HEAP_GRANULES > 1) ? $clog2(HEAP_GRANULES) : 1;
	localparam int CAP_INT = (HEAP_GRANULES * 8 < 32768) ? HEAP_GRANULES * 8 : 32768;
	localparam logic [OFF_W-1:0] LIM_CAP = OFF_W'(CAP_INT);

	typedef enum logic [11:0] {
		S_IDLE    = 12'b000000000001,
		S_A_CHK   = 12'b000000000010,
		S_A_EVAL  = 12'b000000000100,
		S_A_FIT   = 12'b000000001000,
		S_A_SPLIT = 12'b000000010000,
		S_A_GROW  = 12'b000000100000,
		S_A_GROW2 = 12'b000001000000,
		S_F_CHK   = 12'b000010000000,
		S_F_RD    = 12'b000100000000,
		S_F_NXT   = 12'b001000000000,
		S_F_MRG   = 12'b010000000000,
		S_DONE    = 12'b100000000000
	} state_t;

	state_t             state_q;
	logic [OFF_W-1:0]   heap_top_q;
	logic [15:0]        limit_q;
	logic               out_valid_q;
	logic [14:0]        out_addr_q;
	logic [1:0]         out_status_q;

	logic [OFF_W-1:0]   pos_q;
	logic [ALU_W-1:0]   asize_q;
	logic [ALU_W-1:0]   end_q;
	logic [HDR_W-1:0]   sz_q;
	logic [HDR_W-1:0]   nsz_q;
	logic [HDR_W-1:0]   diff_q;
	logic               alloc_q;
	logic [14:0]        res_addr_q;
	logic [1:0]         res_status_q;

	alu_req_t           alu_req;
	alu_res_t           alu_res;

	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [HDR_W-1:0]   ram_wdata;
	logic [AW-1:0]      ram_raddr;
	logic [HDR_W-1:0]   ram_rdata;

	logic [HDR_W-1:0]   rd_sz;
	logic [OFF_W-1:0]   lim;
	logic [ALU_W-1:0]   asize_d;
	logic               a_brk;
	logic               a_fit;
	logic               a_split;
	logic               g_fail;
	logic               f_go;
	logic               f_mrg;
	logic               out_load;

	function automatic logic [AW-1:0] gidx(input logic [OFF_W-1:0] off);
		return AW'(off[OFF_W-1:3]);
	endfunction

	function automatic logic [14:0] pay(input logic [OFF_W-1:0] off);
		return {off[14:3] + 12'd1, 3'b000};
	endfunction

	ffha_alu u_alu (
		.req (alu_req),
		.res (alu_res)
	);

	ffha_ram #(
		.WIDTH (HDR_W),
		.DEPTH (HEAP_GRANULES),
		.AW    (AW)
	) u_hdr_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd_sz   = {ram_rdata[HDR_W-1:3], 3'b000};
	assign lim     = (limit_q > LIM_CAP) ? LIM_CAP : limit_q;
	assign asize_d = (req.req_size <= 16'd8) ? ALU_W'(16) :
		((ALU_W'(req.req_size) + ALU_W'(15)) & ~ALU_W'(7));

	assign a_brk   = (rd_sz == '0) || (alu_res.sum > ALU_W'(heap_top_q));
	assign a_fit   = !alloc_q && !alu_res.lt;
	assign a_split = alu_res.sum[ALU_W-1:4] != '0;
	assign g_fail  = alu_res.lt || (asize_q > alu_res.sum);
	assign f_go    = (rd_sz != '0) && (alu_res.sum < ALU_W'(heap_top_q));
	assign f_mrg   = !ram_rdata[0] && (alu_res.sum <= ALU_W'(heap_top_q));

	assign out_load  = (state_q == S_DONE) && (!out_valid_q || rsp.ready);
	assign req.ready = (state_q == S_IDLE);

	assign rsp.valid        = out_valid_q;
	assign rsp.payload_addr = out_addr_q;
	assign rsp.status       = out_status_q;

	always_comb begin
		alu_req   = '{op: ALU_ADD, a: '0, b: '0};
		ram_we    = 1'b0;
		ram_waddr = gidx(pos_q);
		ram_wdata = '0;
		ram_raddr = gidx(pos_q);
		case (state_q)
			S_IDLE: begin
				alu_req = '{op: ALU_SUB, a: ALU_W'(req.free_addr), b: ALU_W'(8)};
			end
			S_A_EVAL: begin
				alu_req = '{op: ALU_ADD, a: ALU_W'(pos_q), b: ALU_W'(rd_sz)};
			end
			S_A_FIT: begin
				alu_req   = '{op: ALU_SUB, a: ALU_W'(sz_q), b: asize_q};
				ram_we    = a_fit;
				ram_wdata = a_split ? {asize_q[HDR_W-1:1], 1'b1} : {sz_q[HDR_W-1:1], 1'b1};
			end
			S_A_SPLIT: begin
				alu_req   = '{op: ALU_ADD, a: ALU_W'(pos_q), b: asize_q};
				ram_we    = 1'b1;
				ram_waddr = gidx(alu_res.sum[OFF_W-1:0]);
				ram_wdata = {diff_q[HDR_W-1:1], 1'b0};
			end
			S_A_GROW: begin
				alu_req   = '{op: ALU_SUB, a: ALU_W'(lim), b: ALU_W'(heap_top_q)};
				ram_we    = !g_fail;
				ram_waddr = gidx(heap_top_q);
				ram_wdata = {asize_q[HDR_W-1:1], 1'b1};
			end
			S_A_GROW2: begin
				alu_req = '{op: ALU_ADD, a: ALU_W'(heap_top_q), b: asize_q};
			end
			S_F_RD: begin
				alu_req   = '{op: ALU_ADD, a: ALU_W'(pos_q), b: ALU_W'(rd_sz)};
				ram_we    = 1'b1;
				ram_wdata = rd_sz;
				ram_raddr = gidx(alu_res.sum[OFF_W-1:0]);
			end
			S_F_NXT: begin
				alu_req = '{op: ALU_ADD, a: end_q, b: ALU_W'(rd_sz)};
			end
			S_F_MRG: begin
				alu_req   = '{op: ALU_ADD, a: ALU_W'(sz_q), b: ALU_W'(nsz_q)};
				ram_we    = 1'b1;
				ram_wdata = alu_res.sum[HDR_W-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			heap_top_q  <= '0;
			limit_q     <= LIMIT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				limit_q <= cfg_wr_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						if (req.func == FUNC_FREE) begin
							state_q <= (alu_res.lt || req.free_addr[2:0] != 3'd0) ? S_DONE : S_F_CHK;
						end else begin
							state_q <= S_A_CHK;
						end
					end
				end
				S_A_CHK:   state_q <= (pos_q < heap_top_q) ? S_A_EVAL : S_A_GROW;
				S_A_EVAL:  state_q <= a_brk ? S_A_GROW : S_A_FIT;
				S_A_FIT: begin
					if (a_fit) begin
						state_q <= a_split ? S_A_SPLIT : S_DONE;
					end else begin
						state_q <= S_A_CHK;
					end
				end
				S_A_SPLIT: state_q <= S_DONE;
				S_A_GROW:  state_q <= g_fail ? S_DONE : S_A_GROW2;
				S_A_GROW2: begin
					heap_top_q <= alu_res.sum[OFF_W-1:0];
					state_q    <= S_DONE;
				end
				S_F_CHK:   state_q <= (pos_q < heap_top_q) ? S_F_RD : S_DONE;
				S_F_RD:    state_q <= f_go ? S_F_NXT : S_DONE;
				S_F_NXT:   state_q <= f_mrg ? S_F_MRG : S_DONE;
				S_F_MRG:   state_q <= S_DONE;
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default:   state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_addr_q   <= res_addr_q;
			out_status_q <= res_status_q;
		end
		case (state_q)
			S_IDLE: begin
				if (req.func == FUNC_FREE) begin
					pos_q        <= alu_res.sum[OFF_W-1:0];
					res_addr_q   <= '0;
					res_status_q <= ST_FREED;
				end else begin
					pos_q   <= '0;
					asize_q <= asize_d;
				end
			end
			S_A_EVAL: begin
				sz_q    <= rd_sz;
				alloc_q <= ram_rdata[0];
				end_q   <= alu_res.sum;
			end
			S_A_FIT: begin
				if (a_fit) begin
					res_addr_q   <= pay(pos_q);
					res_status_q <= ST_ALLOCATED;
					diff_q       <= alu_res.sum[HDR_W-1:0];
				end else begin
					pos_q <= end_q[OFF_W-1:0];
				end
			end
			S_A_GROW: begin
				if (g_fail) begin
					res_addr_q   <= '0;
					res_status_q <= ST_NO_SPACE;
				end else begin
					res_addr_q   <= pay(heap_top_q);
					res_status_q <= ST_ALLOCATED;
				end
			end
			S_F_RD: begin
				sz_q  <= rd_sz;
				end_q <= alu_res.sum;
			end
			S_F_NXT: begin
				nsz_q <= rd_sz;
			end
			default: begin
			end
		endcase
	end

	a_top_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		heap_top_q[2:0] == 3'd0)
		else $error("heap top not 8-byte aligned");

	a_top_cap: assert property (@(posedge clk) disable iff (!arst_n)
		heap_top_q <= LIM_CAP)
		else $error("heap top beyond capacity");

	a_split_after_fit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_A_SPLIT |-> $past(state_q) == S_A_FIT)
		else $error("split without a fitting block");

	a_fail_no_addr: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.status == ST_NO_SPACE || rsp.status == ST_FREED)
		|-> rsp.payload_addr == '0)
		else $error("non-zero address on free or failed item");

	a_walk_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_A_CHK || state_q == S_A_EVAL || state_q == S_A_FIT)
		|-> pos_q[2:0] == 3'd0)
		else $error("walk position not aligned");

endmodule
`default_nettype wire

### tb/sv/testbench.sv
// Self-checking testbench for the first-fit heap allocator, predicting every reply from a heap model.
`timescale 1ns / 100ps
module testbench
	import ffha_pkg::*;
();

	localparam int HEAP_GRANULES = 4096;
	localparam int unsigned SIZE_MASK = 32'h1FFF8;

	typedef struct packed {
		logic        func;
		logic [15:0] req_size;
		logic [14:0] free_addr;
	} heap_cmd_t;

	typedef struct packed {
		logic [14:0] payload_addr;
		logic [1:0]  status;
	} heap_reply_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [15:0] cfg_wr_data;

	ffha_req_if req_ch ();
	ffha_rsp_if rsp_ch ();

	first_fit_heap_allocator #(
		.HEAP_GRANULES(HEAP_GRANULES)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.req        (req_ch),
		.rsp        (rsp_ch)
	);

	// heap model
	logic [16:0] model_hdr [HEAP_GRANULES];
	bit          model_hdr_set [HEAP_GRANULES];
	logic [15:0] model_top = '0;
	logic [15:0] model_limit = LIMIT_RESET;

	heap_reply_t awaited_replies [$];
	int unsigned live_payloads [$];
	int unsigned recent_frees [$];

	bit traffic_idles = 1'b1;
	int hold_request = 0;
	int fail_count = 0;
	int n_granted = 0;
	int n_refused = 0;
	int n_frees = 0;
	int n_limit_writes = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic void store_header(input int unsigned off, input int unsigned value);
		int unsigned g;
		g = off >> 3;
		if (g < HEAP_GRANULES) begin
			model_hdr[g] = 17'(value);
			model_hdr_set[g] = 1'b1;
		end
	endfunction

	// Returns 1 when the item would read a header that was never written; state is
	// then left alone. State is updated only when commit is set.
	function automatic bit predict_heap_op(input heap_cmd_t cmd, input bit commit,
			output heap_reply_t reply);
		int unsigned asize, req, pos, steps, entry, sz, lim, top, blk, nxt, nentry, merged;
		bit found;
		found = 1'b0;
		sz = 0;
		top = model_top;
		reply.payload_addr = '0;
		if (cmd.func == FUNC_ALLOC) begin
			reply.status = ST_ALLOCATED;
			lim = model_limit;
			if (lim > HEAP_GRANULES * 8)
				lim = HEAP_GRANULES * 8;
			if (lim > 32768)
				lim = 32768;
			req = cmd.req_size;
			asize = (req <= 8) ? 16 : 8 + ((req + 7) / 8) * 8;
			pos = 0;
			steps = 0;
			while (!found && pos < top && steps < HEAP_GRANULES) begin
				if (!model_hdr_set[pos >> 3])
					return 1'b1;
				entry = model_hdr[pos >> 3];
				sz = entry & SIZE_MASK;
				if (sz == 0 || pos + sz > top)
					break;
				if ((entry & 1) == 0 && sz >= asize) begin
					found = 1'b1;
				end else begin
					pos += sz;
					steps++;
				end
			end
			if (found) begin
				reply.payload_addr = 15'(pos + 8);
				if (commit) begin
					if (sz - asize >= 16) begin
						store_header(pos, asize | 1);
						store_header(pos + asize, sz - asize);
					end else begin
						store_header(pos, sz | 1);
					end
				end
			end else if (top > lim || asize > lim - top) begin
				reply.status = ST_NO_SPACE;
			end else begin
				reply.payload_addr = 15'(top + 8);
				if (commit) begin
					store_header(top, asize | 1);
					model_top = 16'(top + asize);
				end
			end
		end else begin
			reply.status = ST_FREED;
			if (cmd.free_addr >= 15'd8 && cmd.free_addr[2:0] == 3'd0) begin
				blk = cmd.free_addr - 8;
				if (blk < top) begin
					if (!model_hdr_set[blk >> 3])
						return 1'b1;
					sz = model_hdr[blk >> 3] & SIZE_MASK;
					merged = sz;
					nxt = blk + sz;
					if (sz != 0 && nxt < top) begin
						if (!model_hdr_set[nxt >> 3])
							return 1'b1;
						nentry = model_hdr[nxt >> 3];
						if ((nentry & 1) == 0 && nxt + (nentry & SIZE_MASK) <= top)
							merged = sz + (nentry & SIZE_MASK);
					end
					if (commit)
						store_header(blk, merged);
				end
			end
		end
		return 1'b0;
	endfunction

	function automatic heap_cmd_t alloc_cmd(input int unsigned bytes);
		heap_cmd_t cmd;
		cmd.func = FUNC_ALLOC;
		cmd.req_size = 16'(bytes);
		cmd.free_addr = 15'($urandom);
		return cmd;
	endfunction

	function automatic heap_cmd_t free_cmd(input int unsigned addr);
		heap_cmd_t cmd;
		cmd.func = FUNC_FREE;
		cmd.req_size = 16'($urandom_range(0, 32768));
		cmd.free_addr = 15'(addr);
		return cmd;
	endfunction

	// mostly small allocations and frees of live blocks, the rest double frees,
	// frees at arbitrary aligned offsets and plain noise
	function automatic heap_cmd_t random_heap_cmd();
		heap_cmd_t cmd;
		int unsigned pick, top;
		top = model_top;
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			cmd = alloc_cmd($urandom_range(0, 32768));
			pick = $urandom_range(0, 99);
			if (pick < 70)
				cmd.req_size = 16'($urandom_range(0, 64));
			else if (pick < 90)
				cmd.req_size = 16'($urandom_range(65, 512));
			else if (pick < 97)
				cmd.req_size = 16'($urandom_range(513, 2048));
		end else if (pick < 82 && live_payloads.size() > 0) begin
			cmd = free_cmd(live_payloads[$urandom_range(0, live_payloads.size() - 1)]);
		end else if (pick < 89 && recent_frees.size() > 0) begin
			cmd = free_cmd(recent_frees[$urandom_range(0, recent_frees.size() - 1)]);
		end else if (pick < 95 && top >= 8) begin
			cmd = free_cmd($urandom_range(1, top / 8) * 8);
		end else begin
			cmd = free_cmd($urandom_range(0, 32767));
		end
		return cmd;
	endfunction

	function automatic int pick_gap();
		int unsigned r;
		if (!traffic_idles)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic req_gap(input int n);
		repeat (n) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
		end
	endtask

	task automatic send_heap_cmd(input heap_cmd_t cmd);
		heap_reply_t reply;
		if (predict_heap_op(cmd, 1'b0, reply))
			return;
		@(negedge clk);
		req_ch.valid <= 1'b1;
		req_ch.func <= cmd.func;
		req_ch.req_size <= cmd.req_size;
		req_ch.free_addr <= cmd.free_addr;
		do @(posedge clk); while (!req_ch.ready);
		void'(predict_heap_op(cmd, 1'b1, reply));
		awaited_replies.push_back(reply);
		if (cmd.func == FUNC_ALLOC) begin
			if (reply.status == ST_ALLOCATED) begin
				live_payloads.push_back(reply.payload_addr);
				n_granted++;
			end else begin
				n_refused++;
			end
		end else begin
			n_frees++;
			for (int i = 0; i < live_payloads.size(); i++) begin
				if (live_payloads[i] == cmd.free_addr) begin
					live_payloads.delete(i);
					break;
				end
			end
			recent_frees.push_back(cmd.free_addr);
			if (recent_frees.size() > 8)
				void'(recent_frees.pop_front());
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (awaited_replies.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_heap_limit(input logic [15:0] value);
		wait_drained();
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		model_limit = value;
		n_limit_writes++;
	endtask

	task automatic test_directed_cases();
		traffic_idles = 1'b1;
		send_heap_cmd(alloc_cmd(32768));
		send_heap_cmd(alloc_cmd(0));
		// zero limit: no growth at all
		write_heap_limit(16'd0);
		send_heap_cmd(alloc_cmd(1));
		send_heap_cmd(free_cmd(8));
		send_heap_cmd(alloc_cmd(8));
		write_heap_limit(16'd96);
		send_heap_cmd(alloc_cmd(9));
		send_heap_cmd(alloc_cmd(24));
		send_heap_cmd(alloc_cmd(16));
		send_heap_cmd(alloc_cmd(0));
		send_heap_cmd(free_cmd(48));
		send_heap_cmd(free_cmd(24));
		send_heap_cmd(alloc_cmd(24));
		send_heap_cmd(alloc_cmd(8));
		send_heap_cmd(free_cmd(0));
		send_heap_cmd(free_cmd(13));
		send_heap_cmd(free_cmd(32767));
		send_heap_cmd(free_cmd(32760));
		// stale header inside a live block
		send_heap_cmd(free_cmd(48));
		send_heap_cmd(free_cmd(80));
		send_heap_cmd(free_cmd(56));
		send_heap_cmd(free_cmd(56));
		send_heap_cmd(alloc_cmd(32767));
		send_heap_cmd(alloc_cmd(40));
	endtask

	task automatic test_output_backpressure();
		write_heap_limit(16'd1024);
		traffic_idles = 1'b0;
		hold_request = 300;
		repeat (10)
			send_heap_cmd(alloc_cmd($urandom_range(0, 40)));
		wait_drained();
	endtask

	task automatic test_random_traffic(input logic [15:0] limit, input int count,
			input bit idles);
		heap_cmd_t cmd;
		heap_reply_t scratch;
		write_heap_limit(limit);
		traffic_idles = idles;
		repeat (count) begin
			do cmd = random_heap_cmd(); while (predict_heap_op(cmd, 1'b0, scratch));
			req_gap(pick_gap());
			send_heap_cmd(cmd);
			if ($urandom_range(0, 39) == 0)
				wait_drained();
		end
	endtask

	task automatic test_heap_full();
		write_heap_limit(16'd32768);
		traffic_idles = 1'b1;
		// grow to the limit exactly, then ask for more
		send_heap_cmd(alloc_cmd(32768 - model_top - 8));
		send_heap_cmd(alloc_cmd(8));
		send_heap_cmd(alloc_cmd(32768));
		test_random_traffic(16'd32768, 40, 1'b1);
	endtask

	initial begin : reply_checker
		int unsigned stall;
		int unsigned hold;
		heap_reply_t want;
		stall = 0;
		hold = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
				if (awaited_replies.size() == 0) begin
					$display("%0t: unexpected reply, payload_addr %0d status %0d", $time,
						rsp_ch.payload_addr, rsp_ch.status);
					fail_count++;
				end else begin
					want = awaited_replies.pop_front();
					if (rsp_ch.payload_addr !== want.payload_addr) begin
						$display("%0t: payload_addr expected %0d, got %0d", $time,
							want.payload_addr, rsp_ch.payload_addr);
						fail_count++;
					end
					if (rsp_ch.status !== want.status) begin
						$display("%0t: status expected %0d, got %0d", $time,
							want.status, rsp_ch.status);
						fail_count++;
					end
				end
			end
			@(negedge clk);
			if (hold_request != 0) begin
				hold = hold_request;
				hold_request = 0;
			end
			if (hold != 0) begin
				hold--;
				rsp_ch.ready <= 1'b0;
			end else if (stall != 0) begin
				stall--;
				rsp_ch.ready <= 1'b0;
			end else if (traffic_idles && $urandom_range(0, 99) < 25) begin
				stall = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50) : $urandom_range(0, 2);
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		req_ch.valid = 1'b0;
		req_ch.func = FUNC_ALLOC;
		req_ch.req_size = '0;
		req_ch.free_addr = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_cases();
		test_output_backpressure();
		test_random_traffic(16'd16, 40, 1'b1);
		test_random_traffic(16'd1024, 140, 1'b1);
		test_random_traffic(16'd4096, 130, 1'b0);
		test_random_traffic(16'd200, 60, 1'b1);
		test_random_traffic(16'd2048, 90, 1'b1);
		test_heap_full();

		wait_drained();
		repeat (20) @(posedge clk);
		$display("Covered %0d allocations granted, %0d refused for space, %0d frees.",
			n_granted, n_refused, n_frees);
		$display("Heap limit set %0d times; heap ended at %0d bytes.", n_limit_writes,
			model_top);
		if (fail_count == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

	initial begin
		#100000000;
		$display("timeout");
		$display("testbench failed");
		$finish;
	end

endmodule
